>>> src/closest_point_on_triangle_defines.svh
// Assertion shorthands used by the checker file cpt_check.sv.
`ifndef CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define CPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define CPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication checked at every edge, reset included.
`define CPT_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/cpt_pkg.sv
package cpt_pkg;

	localparam int COORD_W     = 32;
	localparam int DIFF_W      = COORD_W + 1;      // coordinate difference
	localparam int PROD_W      = 2 * DIFF_W;       // one term of a dot product
	localparam int DOT_W       = PROD_W + 2;       // d1..d6
	localparam int VW_W        = 2 * DOT_W + 1;    // va, vb, vc
	localparam int WT_W        = VW_W + 2;         // weights and denominators
	localparam int NUM_W       = DIFF_W + WT_W + 1; // e1*n1 + e2*n2
	localparam int QUO_W       = COORD_W + 2;      // quotient bits kept before saturation
	localparam int REM_W       = NUM_W + 2;        // divider remainder
	localparam int MUL_CHUNK   = 34;
	localparam int MUL_LAT     = 4;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		RGN_VERT_A  = 3'd0,
		RGN_VERT_B  = 3'd1,
		RGN_EDGE_AB = 3'd2,
		RGN_VERT_C  = 3'd3,
		RGN_EDGE_AC = 3'd4,
		RGN_EDGE_BC = 3'd5,
		RGN_INSIDE  = 3'd6
	} region_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic signed [COORD_W-1:0] vert_a_x;
		logic signed [COORD_W-1:0] vert_a_y;
		logic signed [COORD_W-1:0] vert_a_z;
		logic signed [COORD_W-1:0] vert_b_x;
		logic signed [COORD_W-1:0] vert_b_y;
		logic signed [COORD_W-1:0] vert_b_z;
		logic signed [COORD_W-1:0] vert_c_x;
		logic signed [COORD_W-1:0] vert_c_y;
		logic signed [COORD_W-1:0] vert_c_z;
	} query_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] near_x;
		logic signed [COORD_W-1:0] near_y;
		logic signed [COORD_W-1:0] near_z;
		logic [2:0]                region;
		logic                      degenerate;
	} result_t;

	typedef logic [2:0][COORD_W-1:0] coord3_t;
	typedef logic [2:0][DIFF_W-1:0]  diff3_t;

	// classified query: near = base + round((e1*n1 + e2*n2) / den)
	typedef struct packed {
		coord3_t                base;
		diff3_t                 e1;
		diff3_t                 e2;
		logic signed [WT_W-1:0] n1;
		logic signed [WT_W-1:0] n2;
		logic signed [WT_W-1:0] den;
		region_t                region;
		logic                   degen;
	} job_t;

endpackage

>>> src/closest_point_on_triangle.sv
// Channel   Dir  Handshake                    Payload
// query     in   query_valid / query_ready    query_t: point p, vertices a, b, c
// result    out  result_valid / result_ready  result_t: near point, region, degenerate
//
// One transaction per clock in both directions while result_ready stays high; every query gives one result.
// A query passes through the front (dot products, weights, region pick), then the job
// queue, then the back (numerator multiplies, then one quotient bit per stage over the
// divider's 34 quotient stages).
// arst_n clears all valid bits and queue pointers; data registers are not reset.
// A stall on result freezes the back only; the front keeps taking queries until the
// DEPTH-entry job queue is full with a job waiting at the front's end; then query_ready drops.
module closest_point_on_triangle
	import cpt_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_ready,
	input  query_t  query,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// front -> queue
	logic push;
	logic full;
	job_t job_in;

	// queue -> back
	logic pop;
	logic avail;
	job_t job_out;

	// Front: vector differences, the six dot products d1..d6, the weights
	// va/vb/vc and the Voronoi region tests, ending in one classified job.
	cpt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_ready (query_ready),
		.query       (query),
		.full        (full),
		.push        (push),
		.job         (job_in)
	);

	// Decouples the two halves so a result stall does not stop the front at once.
	cpt_queue #(.DEPTH(DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.full   (full),
		.avail  (avail)
	);

	// Back: base + rounded ratio per coordinate, saturated, into the output register.
	cpt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (avail),
		.pop          (pop),
		.job          (job_out),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> src/cpt_mul.sv
// Signed multiplier, sign-magnitude over MUL_CHUNK-bit partial products, MUL_LAT stages.
module cpt_mul
	import cpt_pkg::*;
#(
	parameter int AW = DIFF_W,
	parameter int BW = DIFF_W
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic [AW+BW-1:0]     p
);

	localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PW = AW + BW;
	localparam int RW = (NB + 1) * MUL_CHUNK;
	localparam int TW = (NA + NB) * MUL_CHUNK;

	logic [AW-1:0]             a_mag;
	logic [BW-1:0]             b_mag;
	logic [NA*MUL_CHUNK-1:0]   am_s1;
	logic [NB*MUL_CHUNK-1:0]   bm_s1;
	logic                      neg_s1, neg_s2, neg_s3;
	logic [2*MUL_CHUNK-1:0]    pp_s2 [NA][NB];
	logic [RW-1:0]             row_c [NA];
	logic [RW-1:0]             row_s3 [NA];
	logic [TW-1:0]             total_c;
	logic [PW-1:0]             mag_c;

	always_comb begin
		a_mag = a[AW-1] ? (~a + 1'b1) : a;
		b_mag = b[BW-1] ? (~b + 1'b1) : b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1  <= (NA*MUL_CHUNK)'(a_mag);
			bm_s1  <= (NB*MUL_CHUNK)'(b_mag);
			neg_s1 <= a[AW-1] ^ b[BW-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= am_s1[i*MUL_CHUNK +: MUL_CHUNK]
						* bm_s1[j*MUL_CHUNK +: MUL_CHUNK];
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			p      <= neg_s3 ? (~mag_c + 1'b1) : mag_c;
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s2[i][j]) << (j * MUL_CHUNK));
			end
		end
	end

	always_comb begin
		total_c = '0;
		for (int i = 0; i < NA; i++) begin
			total_c = total_c + (TW'(row_s3[i]) << (i * MUL_CHUNK));
		end
		mag_c = total_c[PW-1:0];
	end

endmodule

>>> src/cpt_front.sv
// Front: differences, six dot products, region weights, region decision.
module cpt_front
	import cpt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   query_valid,
	output logic   query_ready,
	input  query_t query,
	input  logic   full,
	output logic   push,
	output job_t   job
);

	localparam int DOT_ST = 1 + MUL_LAT;
	localparam int SUM_ST = DOT_ST + 1;
	localparam int VW_ST  = SUM_ST + MUL_LAT;
	localparam int FL     = VW_ST + 2;
	localparam int LA [6] = '{0, 2, 4, 0, 2, 4};
	localparam int LB [6] = '{3, 1, 1, 5, 5, 3};

	typedef struct packed {
		coord3_t a;
		coord3_t b;
		coord3_t c;
		diff3_t  ab;
		diff3_t  ac;
		diff3_t  bc;
	} side_t;

	typedef struct packed {
		logic vert_a;
		logic vert_b;
		logic edge_ab;
		logic vert_c;
		logic edge_ac;
	} flags_t;

	logic                      en;
	logic [FL:1]               vld_q;
	coord3_t                   qp, qa, qb, qc;
	side_t                     side_q [1:FL-1];
	diff3_t                    ap_s1, bp_s1, cp_s1;
	diff3_t                    lhs_c [6];
	diff3_t                    rhs_c [6];
	logic signed [PROD_W-1:0]  prod [6][3];
	logic signed [DOT_W-1:0]   dot_q [SUM_ST:VW_ST][6];
	logic signed [2*DOT_W-1:0] wprod [6];
	logic signed [VW_W-1:0]    va_s11, vb_s11, vc_s11;
	logic signed [DOT_W-1:0]   d1_s11, d2_s11;
	logic signed [DOT_W:0]     d13_s11, d26_s11, e43_s11, e56_s11;
	flags_t                    flg_s11;
	logic signed [WT_W-1:0]    den_in, den_bc;
	job_t                      job_c, job_s12;

	function automatic logic [DIFF_W-1:0] sub_c(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		sub_c = {x[COORD_W-1], x} - {y[COORD_W-1], y};
	endfunction

	assign en          = !full || !vld_q[FL];
	assign query_ready = en;
	assign push        = vld_q[FL] && !full;
	assign job         = job_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[FL-1:1], query_valid};
		end
	end

	always_comb begin
		qp = {query.point_z, query.point_y, query.point_x};
		qa = {query.vert_a_z, query.vert_a_y, query.vert_a_x};
		qb = {query.vert_b_z, query.vert_b_y, query.vert_b_x};
		qc = {query.vert_c_z, query.vert_c_y, query.vert_c_x};
	end

	// s1: edge and point vectors
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[1].a <= qa;
			side_q[1].b <= qb;
			side_q[1].c <= qc;
			for (int k = 0; k < 3; k++) begin
				side_q[1].ab[k] <= sub_c(qb[k], qa[k]);
				side_q[1].ac[k] <= sub_c(qc[k], qa[k]);
				side_q[1].bc[k] <= sub_c(qc[k], qb[k]);
				ap_s1[k]        <= sub_c(qp[k], qa[k]);
				bp_s1[k]        <= sub_c(qp[k], qb[k]);
				cp_s1[k]        <= sub_c(qp[k], qc[k]);
			end
			for (int i = 2; i < FL; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// d1..d6 in order: ab.ap, ac.ap, ab.bp, ac.bp, ab.cp, ac.cp
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			lhs_c[k] = (k % 2 == 0) ? side_q[1].ab : side_q[1].ac;
			rhs_c[k] = (k < 2) ? ap_s1 : ((k < 4) ? bp_s1 : cp_s1);
		end
	end

	for (genvar k = 0; k < 6; k++) begin : g_dot
		for (genvar j = 0; j < 3; j++) begin : g_term
			cpt_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mul (
				.clk (clk),
				.en  (en),
				.a   (lhs_c[k][j]),
				.b   (rhs_c[k][j]),
				.p   (prod[k][j])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) begin
				dot_q[SUM_ST][k] <= DOT_W'(prod[k][0]) + DOT_W'(prod[k][1])
					+ DOT_W'(prod[k][2]);
			end
			for (int i = SUM_ST + 1; i <= VW_ST; i++) begin
				dot_q[i] <= dot_q[i-1];
			end
		end
	end

	// d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
	for (genvar g = 0; g < 6; g++) begin : g_wt
		cpt_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul (
			.clk (clk),
			.en  (en),
			.a   (dot_q[SUM_ST][LA[g]]),
			.b   (dot_q[SUM_ST][LB[g]]),
			.p   (wprod[g])
		);
	end

	// s11: region weights and dot tests
	always_ff @(posedge clk) begin
		if (en) begin
			vc_s11  <= VW_W'(wprod[0]) - VW_W'(wprod[1]);
			vb_s11  <= VW_W'(wprod[2]) - VW_W'(wprod[3]);
			va_s11  <= VW_W'(wprod[4]) - VW_W'(wprod[5]);
			d1_s11  <= dot_q[VW_ST][0];
			d2_s11  <= dot_q[VW_ST][1];
			d13_s11 <= (DOT_W+1)'(dot_q[VW_ST][0]) - (DOT_W+1)'(dot_q[VW_ST][2]);
			d26_s11 <= (DOT_W+1)'(dot_q[VW_ST][1]) - (DOT_W+1)'(dot_q[VW_ST][5]);
			e43_s11 <= (DOT_W+1)'(dot_q[VW_ST][3]) - (DOT_W+1)'(dot_q[VW_ST][2]);
			e56_s11 <= (DOT_W+1)'(dot_q[VW_ST][4]) - (DOT_W+1)'(dot_q[VW_ST][5]);
			flg_s11.vert_a  <= (dot_q[VW_ST][0] <= 0) && (dot_q[VW_ST][1] <= 0);
			flg_s11.vert_b  <= (dot_q[VW_ST][2] >= 0)
				&& (dot_q[VW_ST][3] <= dot_q[VW_ST][2]);
			flg_s11.edge_ab <= (dot_q[VW_ST][0] >= 0) && (dot_q[VW_ST][2] <= 0);
			flg_s11.vert_c  <= (dot_q[VW_ST][5] >= 0)
				&& (dot_q[VW_ST][4] <= dot_q[VW_ST][5]);
			flg_s11.edge_ac <= (dot_q[VW_ST][1] >= 0) && (dot_q[VW_ST][5] <= 0);
		end
	end

	// s12: pick region in the standard test order
	always_comb begin
		den_in = WT_W'(va_s11) + WT_W'(vb_s11) + WT_W'(vc_s11);
		den_bc = WT_W'(e43_s11) + WT_W'(e56_s11);
		job_c.base   = side_q[FL-1].a;
		job_c.e1     = side_q[FL-1].ab;
		job_c.e2     = side_q[FL-1].ac;
		job_c.n1     = '0;
		job_c.n2     = '0;
		job_c.den    = WT_W'(1);
		job_c.region = RGN_VERT_A;
		job_c.degen  = 1'b0;
		priority if (flg_s11.vert_a) begin
			job_c.region = RGN_VERT_A;
		end else if (flg_s11.vert_b) begin
			job_c.base   = side_q[FL-1].b;
			job_c.region = RGN_VERT_B;
		end else if (vc_s11 <= 0 && flg_s11.edge_ab) begin
			job_c.n1     = WT_W'(d1_s11);
			job_c.den    = WT_W'(d13_s11);
			job_c.region = RGN_EDGE_AB;
		end else if (flg_s11.vert_c) begin
			job_c.base   = side_q[FL-1].c;
			job_c.region = RGN_VERT_C;
		end else if (vb_s11 <= 0 && flg_s11.edge_ac) begin
			job_c.n2     = WT_W'(d2_s11);
			job_c.den    = WT_W'(d26_s11);
			job_c.region = RGN_EDGE_AC;
		end else if (va_s11 <= 0 && e43_s11 >= 0 && e56_s11 >= 0) begin
			job_c.base   = side_q[FL-1].b;
			job_c.e1     = side_q[FL-1].bc;
			job_c.n1     = WT_W'(e43_s11);
			job_c.den    = den_bc;
			job_c.region = RGN_EDGE_BC;
		end else if (den_in == '0) begin
			job_c.degen  = 1'b1;
		end else begin
			job_c.n1     = WT_W'(vb_s11);
			job_c.n2     = WT_W'(vc_s11);
			job_c.den    = den_in;
			job_c.region = RGN_INSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s12 <= job_c;
		end
	end

endmodule

>>> src/cpt_queue.sv
// Small FIFO of classified jobs between front and back.
module cpt_queue
	import cpt_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic full,
	output logic avail
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          entry_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign avail = (cnt_q != '0);
	assign rdata = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wdata;
		end
	end

endmodule

>>> src/cpt_div.sv
// One coordinate: base + round(num/den), ties away from zero, saturated.
// Restoring division, one quotient bit per stage.
module cpt_div
	import cpt_pkg::*;
(
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [WT_W-1:0] den,
	input  logic [COORD_W-1:0]     base,
	output logic [COORD_W-1:0]     near
);

	localparam int DV_W  = WT_W + 1;
	localparam int SUM_W = QUO_W + 2;

	typedef struct packed {
		logic [REM_W-1:0]   rem;
		logic [DV_W-1:0]    dv;
		logic [QUO_W-1:0]   quo;
		logic               neg;
		logic               zero;
		logic               ovf;
		logic [COORD_W-1:0] base;
	} lane_t;

	logic [NUM_W-1:0]   n_mag;
	logic [WT_W-1:0]    d_mag;
	lane_t              pre_q;
	lane_t              first_c;
	lane_t              st_q [0:QUO_W];
	logic [SUM_W-1:0]   sum_c;
	logic [COORD_W-1:0] sat_c;

	always_comb begin
		n_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
		d_mag = den[WT_W-1] ? (~den + 1'b1) : den;
	end

	// quotient too wide for QUO_W bits means the sum saturates
	always_comb begin
		first_c     = pre_q;
		first_c.ovf = pre_q.rem >= (REM_W'(pre_q.dv) << QUO_W);
	end

	// remainder starts at 2|num| + |den|, divisor is 2|den|
	always_ff @(posedge clk) begin
		if (en) begin
			pre_q.rem  <= {1'b0, n_mag, 1'b0} + REM_W'(d_mag);
			pre_q.dv   <= {d_mag, 1'b0};
			pre_q.quo  <= '0;
			pre_q.neg  <= num[NUM_W-1] ^ den[WT_W-1];
			pre_q.zero <= (den == '0);
			pre_q.ovf  <= 1'b0;
			pre_q.base <= base;
			st_q[0]    <= first_c;
		end
	end

	for (genvar gi = 1; gi <= QUO_W; gi++) begin : g_bit
		logic [REM_W-1:0] dsh;
		logic             ge;
		lane_t            nxt;
		always_comb begin
			dsh     = REM_W'(st_q[gi-1].dv) << (QUO_W - gi);
			ge      = st_q[gi-1].rem >= dsh;
			nxt     = st_q[gi-1];
			nxt.rem = ge ? (st_q[gi-1].rem - dsh) : st_q[gi-1].rem;
			nxt.quo = {st_q[gi-1].quo[QUO_W-2:0], ge};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_q[gi] <= nxt;
			end
		end
	end

	always_comb begin
		if (st_q[QUO_W].neg) begin
			sum_c = SUM_W'(signed'(st_q[QUO_W].base)) - SUM_W'(st_q[QUO_W].quo);
		end else begin
			sum_c = SUM_W'(signed'(st_q[QUO_W].base)) + SUM_W'(st_q[QUO_W].quo);
		end
		if (sum_c[SUM_W-1:COORD_W-1] == '0 || sum_c[SUM_W-1:COORD_W-1] == '1) begin
			sat_c = sum_c[COORD_W-1:0];
		end else begin
			sat_c = {sum_c[SUM_W-1], {(COORD_W-1){!sum_c[SUM_W-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (st_q[QUO_W].zero) begin
				near <= st_q[QUO_W].base;
			end else if (st_q[QUO_W].ovf) begin
				near <= {st_q[QUO_W].neg, {(COORD_W-1){!st_q[QUO_W].neg}}};
			end else begin
				near <= sat_c;
			end
		end
	end

endmodule

>>> src/cpt_back.sv
// Back: numerators, three divider lanes, output register.
module cpt_back
	import cpt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    avail,
	output logic    pop,
	input  job_t    job,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int PRE     = MUL_LAT + 2;
	localparam int DIV_LAT = QUO_W + 3;
	localparam int BL      = PRE + DIV_LAT;

	typedef struct packed {
		coord3_t                base;
		logic signed [WT_W-1:0] den;
		region_t                region;
		logic                   degen;
	} tag_t;

	logic                           en;
	logic [BL:1]                    vld_q;
	job_t                           job_b1;
	tag_t                           tag_q [2:PRE];
	region_t                        rg_q [PRE+1:BL];
	logic [PRE+1:BL]                dg_q;
	logic signed [DIFF_W+WT_W-1:0]  pa [3];
	logic signed [DIFF_W+WT_W-1:0]  pb [3];
	logic signed [NUM_W-1:0]        num_b6 [3];
	logic [COORD_W-1:0]             near [3];

	assign en           = !vld_q[BL] || result_ready;
	assign pop          = en && avail;
	assign result_valid = vld_q[BL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[BL-1:1], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_b1            <= job;
			tag_q[2].base     <= job_b1.base;
			tag_q[2].den      <= job_b1.den;
			tag_q[2].region   <= job_b1.region;
			tag_q[2].degen    <= job_b1.degen;
			for (int i = 3; i <= PRE; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
			for (int k = 0; k < 3; k++) begin
				num_b6[k] <= NUM_W'(pa[k]) + NUM_W'(pb[k]);
			end
			rg_q[PRE+1] <= tag_q[PRE].region;
			dg_q[PRE+1] <= tag_q[PRE].degen;
			for (int i = PRE + 2; i <= BL; i++) begin
				rg_q[i] <= rg_q[i-1];
				dg_q[i] <= dg_q[i-1];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		cpt_mul #(.AW(DIFF_W), .BW(WT_W)) u_mul1 (
			.clk (clk),
			.en  (en),
			.a   (job_b1.e1[k]),
			.b   (job_b1.n1),
			.p   (pa[k])
		);
		cpt_mul #(.AW(DIFF_W), .BW(WT_W)) u_mul2 (
			.clk (clk),
			.en  (en),
			.a   (job_b1.e2[k]),
			.b   (job_b1.n2),
			.p   (pb[k])
		);
		cpt_div u_div (
			.clk  (clk),
			.en   (en),
			.num  (num_b6[k]),
			.den  (tag_q[PRE].den),
			.base (tag_q[PRE].base[k]),
			.near (near[k])
		);
	end

	always_comb begin
		result.near_x     = near[0];
		result.near_y     = near[1];
		result.near_z     = near[2];
		result.region     = rg_q[BL];
		result.degenerate = dg_q[BL];
	end

endmodule

>>> src/cpt_check.sv
`include "closest_point_on_triangle_defines.svh"

module cpt_check
	import cpt_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    query_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	`CPT_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")
	`CPT_ASSERT_IMPLY(a_region, clk, arst_n, result_valid, result.region <= RGN_INSIDE, "bad region code")
	`CPT_ASSERT_IMPLY(a_degen, clk, arst_n, result_valid && result.degenerate, result.region == RGN_VERT_A, "degenerate without vertex a")
	`CPT_ASSERT_ALWAYS(a_reset, clk, !arst_n, !result_valid && query_ready, "reset state wrong")

endmodule

bind closest_point_on_triangle cpt_check u_check (.*);
